// ----- rtl/assert_macros.svh -----
// Assertion macros shared by the palette matcher RTL.
// Needs a clock named clk and an active-low reset named arst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check on every rising edge, skipped while reset is asserted.
`define NPCM_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Check on every rising edge, reset included.
`define NPCM_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ----- rtl/npcm_pkg.sv -----
// Shared types and constants for the nearest palette color matcher.
// No dependencies.
package npcm_pkg;

	localparam int PaletteDepthDefault = 256;
	localparam int ChanW  = 8;
	localparam int EntryW = 4 * ChanW;
	localparam int SqW    = 2 * ChanW;
	localparam int DistW  = 18;
	localparam int IdxW   = 8;
	localparam int UsedW  = 9;
	localparam int ApbAddrW = 3;
	localparam int ApbDataW = 32;

	typedef enum logic {
		OpLoad     = 1'b0,
		OpClassify = 1'b1
	} op_t;

	// Register select is paddr[2]; the low two bits are the byte offset.
	typedef enum logic {
		RegPaletteUsed = 1'b0
	} reg_sel_t;

	typedef struct packed {
		op_t              operation;
		logic [IdxW-1:0]  entry_index;
		logic [ChanW-1:0] red;
		logic [ChanW-1:0] green;
		logic [ChanW-1:0] blue;
		logic [ChanW-1:0] alpha;
	} pixel_word_t;

	typedef struct packed {
		logic [IdxW-1:0]  palette_index;
		logic [DistW-1:0] best_distance;
		logic             palette_empty;
	} result_word_t;

	// Search token that travels down the chain with one pixel.
	typedef struct packed {
		logic              valid;
		logic [EntryW-1:0] pixel;
		logic              found;
		logic [IdxW-1:0]   lead_idx;
		logic [DistW-1:0]  lead_sqd;
	} token_t;

	// Palette load broadcast to every cell.
	typedef struct packed {
		logic              we;
		logic [IdxW-1:0]   slot;
		logic [EntryW-1:0] entry;
	} load_t;

endpackage

// ----- rtl/npcm_cell.sv -----
// One cell of the matcher chain: holds a palette entry and updates the passing token.
// Depends on npcm_pkg.
module npcm_cell #(
	parameter int Idx = 0
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     adv,
	input  npcm_pkg::load_t          load,
	input  logic [npcm_pkg::UsedW-1:0] count,
	input  npcm_pkg::token_t         tok_in,
	output npcm_pkg::token_t         tok_out
);
	import npcm_pkg::*;

	logic [EntryW-1:0] entry_q;
	token_t            tok_s1;
	logic [SqW-1:0]    sq_s1 [4];
	token_t            tok_s2;
	logic [SqW-1:0]    sq_c [4];
	logic [DistW-1:0]  dist_c;
	logic              take_c;

	// Absolute difference squared, per channel.
	always_comb begin
		for (int c = 0; c < 4; c++) begin
			logic [ChanW-1:0] p;
			logic [ChanW-1:0] e;
			logic [ChanW-1:0] d;
			p = tok_in.pixel[c*ChanW +: ChanW];
			e = entry_q[c*ChanW +: ChanW];
			d = (p >= e) ? (p - e) : (e - p);
			sq_c[c] = SqW'(d) * SqW'(d);
		end
	end

	always_comb begin
		dist_c = DistW'(sq_s1[0]) + DistW'(sq_s1[1]) + DistW'(sq_s1[2]) + DistW'(sq_s1[3]);
		take_c = (UsedW'(Idx) < count) && (!tok_s1.found || (dist_c < tok_s1.lead_sqd));
	end

	always_ff @(posedge clk) begin
		if (load.we && (load.slot == IdxW'(Idx))) begin
			entry_q <= load.entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_s1 <= '0;
			sq_s1  <= '{default: '0};
			tok_s2 <= '0;
		end else if (adv) begin
			tok_s1       <= tok_in;
			sq_s1        <= sq_c;
			tok_s2.valid <= tok_s1.valid;
			tok_s2.pixel <= tok_s1.pixel;
			if (take_c) begin
				tok_s2.found    <= 1'b1;
				tok_s2.lead_idx <= IdxW'(Idx);
				tok_s2.lead_sqd <= dist_c;
			end else begin
				tok_s2.found    <= tok_s1.found;
				tok_s2.lead_idx <= tok_s1.lead_idx;
				tok_s2.lead_sqd <= tok_s1.lead_sqd;
			end
		end
	end

	assign tok_out = tok_s2;

endmodule

// ----- rtl/npcm_chain.sv -----
// Row of matcher cells, one per palette slot, tokens handed cell to cell.
// Depends on npcm_pkg and npcm_cell.
module npcm_chain #(
	parameter int PaletteDepth = npcm_pkg::PaletteDepthDefault
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       adv,
	input  npcm_pkg::load_t            load,
	input  logic [npcm_pkg::UsedW-1:0] count,
	input  npcm_pkg::token_t           head,
	output npcm_pkg::token_t           tail
);
	import npcm_pkg::*;

	token_t link [PaletteDepth+1];

	assign link[0] = head;

	for (genvar k = 0; k < PaletteDepth; k++) begin : g_cell
		npcm_cell #(
			.Idx(k)
		) u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.adv     (adv),
			.load    (load),
			.count   (count),
			.tok_in  (link[k]),
			.tok_out (link[k+1])
		);
	end

	assign tail = link[PaletteDepth];

endmodule

// ----- rtl/nearest_palette_color_match_core.sv -----
// Top level of the nearest palette color matcher: APB register, handshake, result register.
// Depends on npcm_pkg, npcm_chain and assert_macros.svh.
//
// Usage:
//   pixel channel (pixel_valid/pixel_ready/pixel_word) carries two kinds of word.
//   A load word (operation = load) writes entry_index of the palette with its
//   RGBA value and gives no result. A classify word searches entries
//   0 .. palette_used-1 and gives one result word on the result channel:
//   nearest index (lowest on ties), squared distance, and palette_empty when
//   palette_used is zero.
//   The palette lives in a chain of PALETTE_DEPTH cells, one entry each. In each
//   cell a pixel is squared, then summed and compared, each step registered; the
//   result then passes through the result register. Classify words enter one per
//   cycle while the result register is free or being drained; the chain is a
//   pipeline with 2*PALETTE_DEPTH stages. A load word waits until no pixel is in
//   the chain. When the receiver stalls with a result waiting, the whole chain
//   holds and pixel_ready drops for classify words; nothing is lost.
//   Reset clears the count register and the pipeline; palette entries are
//   undefined until loaded. palette_used is written over APB at byte address 0;
//   the user must write it only while the block is idle; the block does not enforce it.
`include "assert_macros.svh"

module nearest_palette_color_match_core #(
	parameter int PALETTE_DEPTH = npcm_pkg::PaletteDepthDefault
) (
	input  logic                          clk,
	input  logic                          arst_n,
	// pixel / load words
	input  logic                          pixel_valid,
	output logic                          pixel_ready,
	input  npcm_pkg::pixel_word_t         pixel_word,
	// result words
	output logic                          result_valid,
	input  logic                          result_ready,
	output npcm_pkg::result_word_t        result_word,
	// configuration
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [npcm_pkg::ApbAddrW-1:0] paddr,
	input  logic [npcm_pkg::ApbDataW-1:0] pwdata,
	output logic [npcm_pkg::ApbDataW-1:0] prdata,
	output logic                          pready
);
	import npcm_pkg::*;

	localparam int Stages    = 2 * PALETTE_DEPTH;
	localparam int InflightW = $clog2(Stages + 1);

	logic [UsedW-1:0]     palette_used_q;
	logic [InflightW-1:0] inflight_q;
	logic                 result_valid_q;
	result_word_t         result_q;

	logic    adv;
	logic    take_pixel;
	logic    take_classify;
	logic    leave_chain;
	load_t   load;
	token_t  head;
	token_t  tail;

	// Configuration register: write on the access phase, register selected by paddr[2].
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			palette_used_q <= '0;
		end else if (psel && penable && pwrite && pready
				&& (reg_sel_t'(paddr[2]) == RegPaletteUsed)) begin
			palette_used_q <= pwdata[UsedW-1:0];
		end
	end

	always_comb begin
		unique case (reg_sel_t'(paddr[2]))
			RegPaletteUsed: prdata = ApbDataW'(palette_used_q);
			default:        prdata = '0;
		endcase
	end

	// Advance the chain whenever the result register is free or being drained.
	assign adv = !result_valid_q || result_ready;

	// Classify words follow the pipeline; load words wait for an empty chain
	// so no pixel in flight sees an entry written after it.
	always_comb begin
		unique case (pixel_word.operation)
			OpClassify: pixel_ready = adv;
			OpLoad:     pixel_ready = (inflight_q == '0);
			default:    pixel_ready = 1'b0;
		endcase
	end

	assign take_pixel    = pixel_valid && pixel_ready;
	assign take_classify = take_pixel && (pixel_word.operation == OpClassify);
	assign leave_chain   = adv && tail.valid;

	always_comb begin
		load.we    = take_pixel && (pixel_word.operation == OpLoad);
		load.slot  = pixel_word.entry_index;
		load.entry = {pixel_word.red, pixel_word.green, pixel_word.blue, pixel_word.alpha};

		head.valid    = take_classify;
		head.pixel    = {pixel_word.red, pixel_word.green, pixel_word.blue, pixel_word.alpha};
		head.found    = 1'b0;
		head.lead_idx = '0;
		head.lead_sqd = '0;
	end

	npcm_chain #(
		.PaletteDepth(PALETTE_DEPTH)
	) u_chain (
		.clk    (clk),
		.arst_n (arst_n),
		.adv    (adv),
		.load   (load),
		.count  (palette_used_q),
		.head   (head),
		.tail   (tail)
	);

	// Track pixels inside the chain: one in on classify, one out into the result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inflight_q <= '0;
		end else if (take_classify && !leave_chain) begin
			inflight_q <= inflight_q + InflightW'(1);
		end else if (!take_classify && leave_chain) begin
			inflight_q <= inflight_q - InflightW'(1);
		end
	end

	// Result register: load from the tail of the chain, hold while stalled.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (adv) begin
			result_valid_q <= tail.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (leave_chain) begin
			result_q.palette_index <= tail.lead_idx;
			result_q.best_distance <= tail.lead_sqd;
			result_q.palette_empty <= !tail.found;
		end
	end

	assign result_valid = result_valid_q;
	assign result_word  = result_q;

	`NPCM_ASSERT(a_load_chain_empty, (load.we |-> (inflight_q == '0)), "load taken with pixels in flight")
	`NPCM_ASSERT(a_inflight_bound, (inflight_q <= InflightW'(Stages)), "in-flight count overflow")
	`NPCM_ASSERT(a_tail_counted, (tail.valid |-> (inflight_q != '0)), "chain output not counted")
	`NPCM_ASSERT(a_empty_zero, ((result_valid_q && result_q.palette_empty) |-> ((result_q.best_distance == '0) && (result_q.palette_index == '0))), "empty result with nonzero fields")
	`NPCM_ASSERT_ALWAYS(a_reset_idle, ((!arst_n) |-> ((inflight_q == '0) && !result_valid_q)), "control state not cleared in reset")

endmodule

// ----- bench/npcm_match_checker.sv -----
`timescale 1ns / 1ps
// Checker for the nearest palette color matcher bench: watches pixel, result and APB traffic,
// predicts every result word and compares it. Depends on npcm_pkg.
module npcm_match_checker #(
	parameter int PALETTE_DEPTH = npcm_pkg::PaletteDepthDefault
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          pixel_valid,
	input  logic                          pixel_ready,
	input  npcm_pkg::pixel_word_t         pixel_word,
	input  logic                          result_valid,
	input  logic                          result_ready,
	input  npcm_pkg::result_word_t        result_word,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [npcm_pkg::ApbAddrW-1:0] paddr,
	input  logic [npcm_pkg::ApbDataW-1:0] pwdata,
	input  logic [npcm_pkg::ApbDataW-1:0] prdata,
	input  logic                          pready,
	output int                            mismatches,
	output int                            awaiting,
	output int                            results_seen
);
	import npcm_pkg::*;

	logic [EntryW-1:0] palette_entries [PALETTE_DEPTH];
	logic [UsedW-1:0]  search_count;
	result_word_t      nearest_q [$];
	result_word_t      want;
	int                mismatch_total;
	int                seen_total;

	// Lowest index wins on equal distance: only a strictly smaller distance replaces.
	function automatic result_word_t nearest_entry(input logic [EntryW-1:0] px);
		result_word_t      best;
		logic [EntryW-1:0] e;
		int                count;
		int                sum_sq;
		int                d;
		best = '0;
		best.palette_empty = 1'b1;
		count = (search_count > PALETTE_DEPTH) ? PALETTE_DEPTH : int'(search_count);
		for (int i = 0; i < count; i++) begin
			e = palette_entries[i];
			sum_sq = 0;
			for (int c = 0; c < 4; c++) begin
				d = int'(px[c*ChanW +: ChanW]) - int'(e[c*ChanW +: ChanW]);
				sum_sq += d * d;
			end
			if (best.palette_empty || sum_sq < int'(best.best_distance)) begin
				best.palette_empty = 1'b0;
				best.best_distance = DistW'(sum_sq);
				best.palette_index = IdxW'(i);
			end
		end
		return best;
	endfunction

	task automatic note_mismatch(input string msg);
		mismatch_total++;
		if (mismatch_total <= 10)
			$display("MISMATCH at %0t: %s", $time, msg);
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			nearest_q.delete();
			search_count = '0;
			mismatch_total = 0;
			seen_total = 0;
			mismatches <= 0;
			awaiting <= 0;
			results_seen <= 0;
		end else begin
			if (psel && penable && pready && reg_sel_t'(paddr[2]) == RegPaletteUsed) begin
				if (pwrite)
					search_count = pwdata[UsedW-1:0];
				else if (prdata[UsedW-1:0] !== search_count)
					note_mismatch($sformatf("palette_used read %0d, expected %0d",
						prdata[UsedW-1:0], search_count));
			end
			// pop before push: a result leaving belongs to an older word
			if (result_valid && result_ready) begin
				seen_total++;
				if (nearest_q.size() == 0) begin
					note_mismatch($sformatf("unexpected result index %0d dist %0d empty %0b",
						result_word.palette_index, result_word.best_distance,
						result_word.palette_empty));
				end else begin
					want = nearest_q.pop_front();
					if (result_word.palette_index !== want.palette_index ||
					    result_word.best_distance !== want.best_distance ||
					    result_word.palette_empty !== want.palette_empty)
						note_mismatch($sformatf(
							"index %0d/%0d dist %0d/%0d empty %0b/%0b (got/expected)",
							result_word.palette_index, want.palette_index,
							result_word.best_distance, want.best_distance,
							result_word.palette_empty, want.palette_empty));
				end
			end
			if (pixel_valid && pixel_ready) begin
				if (pixel_word.operation == OpLoad) begin
					if (pixel_word.entry_index < PALETTE_DEPTH)
						palette_entries[pixel_word.entry_index] = {pixel_word.red,
							pixel_word.green, pixel_word.blue, pixel_word.alpha};
				end else begin
					nearest_q.push_back(nearest_entry({pixel_word.red, pixel_word.green,
						pixel_word.blue, pixel_word.alpha}));
				end
			end
			mismatches <= mismatch_total;
			awaiting <= nearest_q.size();
			results_seen <= seen_total;
		end
	end

endmodule

// ----- bench/nearest_palette_color_match_core_tb.sv -----
`timescale 1ns / 1ps
// Testbench top for nearest_palette_color_match_core: clock, reset, pixel and APB stimulus,
// receiver stalls and verdict. Depends on npcm_pkg, the core RTL and npcm_match_checker.
module nearest_palette_color_match_core_tb;
	import npcm_pkg::*;

	localparam int Depth         = PaletteDepthDefault;
	// drain wait covers the whole chain plus margin for the result register
	localparam int DrainCycles   = 2 * Depth + 16;
	localparam int StallCycles   = 1500;
	localparam int PressureWords = 600;
	localparam int TargetWords   = 1800;

	logic                clk = 1'b0;
	logic                arst_n;
	logic                pixel_valid;
	logic                pixel_ready;
	pixel_word_t         pixel_word;
	logic                result_valid;
	logic                result_ready;
	result_word_t        result_word;
	logic                psel;
	logic                penable;
	logic                pwrite;
	logic [ApbAddrW-1:0] paddr;
	logic [ApbDataW-1:0] pwdata;
	logic [ApbDataW-1:0] prdata;
	logic                pready;

	int mismatches;
	int awaiting;
	int results_seen;

	// idling control shared by sender and receiver
	bit no_idle;
	bit hold_request;

	// what the palette holds, for steering pixels close to real entries
	logic [EntryW-1:0] palette_copy [Depth];
	int loads_sent;
	int classifies_sent;
	int count_writes;

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	nearest_palette_color_match_core #(.PALETTE_DEPTH(Depth)) uut (.*);

	npcm_match_checker #(.PALETTE_DEPTH(Depth)) u_checker (.*);

	initial begin
		#2000000;
		$display("nearest_palette_color_match_core_tb failed");
		$finish;
	end

	// Each channel fully dark or fully lit, picked independently.
	function automatic logic [EntryW-1:0] corner_color();
		logic [EntryW-1:0] rgba;
		for (int c = 0; c < 4; c++)
			rgba[c*ChanW +: ChanW] = $urandom_range(0, 1) ? 8'hFF : 8'h00;
		return rgba;
	endfunction

	// Entry color: random, a corner, or a copy of an earlier entry so ties show up.
	// Only entries below limit are known to be written.
	function automatic logic [EntryW-1:0] pick_entry(input int limit);
		case ($urandom_range(0, 3))
			0: return (limit > 0) ? palette_copy[$urandom_range(0, limit - 1)] : $urandom;
			1: return corner_color();
			default: return $urandom;
		endcase
	endfunction

	// Pixel color: random, exactly an entry, an entry nudged a few steps, or a corner.
	function automatic logic [EntryW-1:0] pick_pixel(input int count);
		logic [EntryW-1:0] px;
		int v;
		if (count > Depth)
			count = Depth;
		if (count == 0)
			return $urandom;
		case ($urandom_range(0, 9))
			0, 1, 2, 3: px = $urandom;
			4, 5: px = palette_copy[$urandom_range(0, count - 1)];
			6, 7, 8: begin
				px = palette_copy[$urandom_range(0, count - 1)];
				for (int c = 0; c < 4; c++) begin
					v = int'(px[c*ChanW +: ChanW]) + int'($urandom_range(0, 6)) - 3;
					if (v < 0)
						v = 0;
					if (v > 255)
						v = 255;
					px[c*ChanW +: ChanW] = v[ChanW-1:0];
				end
			end
			default: px = corner_color();
		endcase
		return px;
	endfunction

	// Offer one word after a random idle gap; hold it until the block takes it.
	task automatic send_word(input op_t op, input logic [IdxW-1:0] slot,
	                         input logic [EntryW-1:0] rgba);
		int gap;
		gap = no_idle ? 0 : $urandom_range(0, 10);
		if (gap > 0) begin
			pixel_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		pixel_word <= {op, slot, rgba};
		pixel_valid <= 1'b1;
		do @(posedge clk); while (!pixel_ready);
		if (op == OpLoad) begin
			palette_copy[slot] = rgba;
			loads_sent++;
		end else begin
			classifies_sent++;
		end
	endtask

	// Drop valid, wait for every predicted result, then let a trailing load finish.
	task automatic settle();
		pixel_valid <= 1'b0;
		@(posedge clk);
		while (awaiting != 0)
			@(posedge clk);
		repeat (DrainCycles) @(posedge clk);
	endtask

	// One APB transfer: setup, access, then the bus parked.
	task automatic apb_access(input logic write, input logic [ApbDataW-1:0] data);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= write;
		paddr <= {RegPaletteUsed, 2'b00};
		pwdata <= data;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	// Change the search count only with the block idle; read it back for the checker.
	task automatic set_palette_used(input int count);
		settle();
		apb_access(1'b1, ApbDataW'(count));
		apb_access(1'b0, '0);
		count_writes++;
	endtask

	// Receiver: random stall before each result word, one long hold-off on request.
	initial begin : receiver
		int wait_cycles;
		result_ready <= 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			wait_cycles = no_idle ? 0 : $urandom_range(0, 10);
			if (hold_request) begin
				hold_request = 1'b0;
				wait_cycles = StallCycles;
			end
			if (wait_cycles > 0) begin
				result_ready <= 1'b0;
				repeat (wait_cycles) @(posedge clk);
			end
			result_ready <= 1'b1;
			do @(posedge clk); while (!result_valid);
		end
	end

	initial begin : stimulus
		int used_now;
		int stream_len;
		int phase;
		// known values on every input before reset lets go
		arst_n <= 1'b0;
		pixel_valid <= 1'b0;
		pixel_word <= '0;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= '0;
		pwdata <= '0;
		no_idle = 1'b0;
		hold_request = 1'b0;
		loads_sent = 0;
		classifies_sent = 0;
		count_writes = 0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset count reads back as zero; empty palette gives index 0 and the empty flag.
		apb_access(1'b0, '0);
		send_word(OpClassify, 8'h00, 32'h0000_0000);
		send_word(OpClassify, 8'hFF, 32'hFFFF_FFFF);

		// Tiny palette: black, white, black again (tie) and mid gray.
		send_word(OpLoad, 8'd0, 32'h0000_0000);
		send_word(OpLoad, 8'd1, 32'hFFFF_FFFF);
		send_word(OpLoad, 8'd2, 32'h0000_0000);
		send_word(OpLoad, 8'd3, 32'h8080_8080);
		set_palette_used(4);
		send_word(OpClassify, 8'h00, 32'h0000_0000); // exact tie between 0 and 2
		send_word(OpClassify, 8'hA5, 32'hFFFF_FFFF);
		send_word(OpClassify, 8'h5A, 32'hFF00_FF00); // equal distance to black and white
		send_word(OpClassify, 8'h01, 32'h8080_8080);
		send_word(OpClassify, 8'h80, 32'h7F7F_7F7F);
		send_word(OpClassify, 8'h7F, 32'h0102_0304);

		// One black entry against a white pixel: the largest distance there is.
		set_palette_used(1);
		send_word(OpClassify, 8'h00, 32'hFFFF_FFFF);

		// Fill every slot so any count is legal from here on; loads stream behind pixels.
		for (int s = 0; s < Depth; s++)
			send_word(OpLoad, IdxW'(s), pick_entry(s));

		// Fill the chain: receiver holds off while pixels keep coming back to back.
		set_palette_used(Depth);
		no_idle = 1'b1;
		hold_request = 1'b1;
		repeat (PressureWords)
			send_word(OpClassify, IdxW'($urandom), pick_pixel(Depth));
		no_idle = 1'b0;

		// Phases: new count, a few loads, then a pixel stream with the odd load mixed in.
		phase = 0;
		while (loads_sent + classifies_sent < TargetWords) begin
			case (phase)
				0: used_now = 511;
				1: used_now = 0;
				2: used_now = 1;
				3: used_now = 2;
				default: begin
					case ($urandom_range(0, 7))
						0: used_now = 0;
						1: used_now = 1;
						2: used_now = Depth;
						3: used_now = $urandom_range(Depth + 1, 511);
						4: used_now = $urandom_range(2, 8);
						default: used_now = $urandom_range(1, Depth);
					endcase
				end
			endcase
			set_palette_used(used_now);
			no_idle = ($urandom_range(0, 3) == 0);
			repeat ($urandom_range(0, 12))
				send_word(OpLoad, IdxW'($urandom), pick_entry(Depth));
			stream_len = $urandom_range(40, 160);
			repeat (stream_len) begin
				if ($urandom_range(0, 24) == 0)
					send_word(OpLoad, IdxW'($urandom), pick_entry(Depth));
				else
					send_word(OpClassify, IdxW'($urandom), pick_pixel(used_now));
			end
			phase++;
		end
		no_idle = 1'b0;

		settle();
		$display("Sent %0d palette loads and %0d pixels over %0d count settings (0, 1, full, >256).",
			loads_sent, classifies_sent, count_writes);
		$display("Checked %0d result words against the predicted nearest entry.", results_seen);
		if (mismatches == 0 && awaiting == 0) begin
			$display("nearest_palette_color_match_core_tb passed");
		end else begin
			$display("nearest_palette_color_match_core_tb failed");
		end
		$finish;
	end

endmodule

// ----- filelist.f -----
+incdir+rtl
rtl/npcm_pkg.sv
rtl/npcm_cell.sv
rtl/npcm_chain.sv
rtl/nearest_palette_color_match_core.sv
bench/npcm_match_checker.sv
bench/nearest_palette_color_match_core_tb.sv
